### hdl/hsva_pkg.sv
// Shared types, widths and helpers for the HSV plus alpha to ARGB converter.
// No dependencies; every hdl/ module imports this package.
package hsva_pkg;

	localparam int FRAC_BITS = 16;
	localparam int IN_W      = FRAC_BITS + 1;
	localparam int H6_W      = IN_W + 3;
	localparam int SEC_W     = H6_W - FRAC_BITS;
	localparam int PROD_W    = 2 * FRAC_BITS + 1;

	typedef logic [IN_W-1:0]      frac_t;
	typedef logic [FRAC_BITS-1:0] ffrac_t;
	typedef logic [SEC_W-1:0]     sector_t;
	typedef logic [PROD_W-1:0]    prod_t;
	typedef logic [7:0]           level_t;

	localparam frac_t ONE = {1'b1, {FRAC_BITS{1'b0}}};

	// hue sectors; anything above SEC_MAGENTA gives black
	localparam sector_t SEC_RED     = SEC_W'(0);
	localparam sector_t SEC_YELLOW  = SEC_W'(1);
	localparam sector_t SEC_GREEN   = SEC_W'(2);
	localparam sector_t SEC_CYAN    = SEC_W'(3);
	localparam sector_t SEC_BLUE    = SEC_W'(4);
	localparam sector_t SEC_MAGENTA = SEC_W'(5);

	// per-stage advance enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

	// clamp a fraction to 1.0
	function automatic frac_t sat_one(frac_t x);
		return (x > ONE) ? ONE : x;
	endfunction

	// 255 * p / ONE^2, rounded half up
	function automatic level_t round_level(prod_t p);
		logic [PROD_W+7:0] w;
		w = {p, 8'b0} - {8'b0, p} + ((PROD_W + 8)'(1) << (2 * FRAC_BITS - 1));
		return w[2*FRAC_BITS+7:2*FRAC_BITS];
	endfunction

endpackage

### hdl/hsva_prep.sv
// Stages 1 and 2: split hue into sector and fraction, clamp inputs, alpha byte,
// then the f*s and (1-f)*s products. Depends on hsva_pkg.
module hsva_prep
	import hsva_pkg::*;
(
	input  logic     clk,
	input  pipe_en_t en,
	input  frac_t    hue,
	input  frac_t    saturation,
	input  frac_t    brightness,
	input  frac_t    alpha,
	output sector_t  sector_s2,
	output ffrac_t   fs_s2,
	output frac_t    nfs_s2,
	output frac_t    oms_s2,
	output frac_t    v_s2,
	output level_t   ab_s2
);

	logic [H6_W-1:0] h6;
	logic [IN_W+7:0] a255;
	level_t          ab;

	sector_t sector_s1;
	ffrac_t  f_s1;
	frac_t   s_s1;
	frac_t   v_s1;
	level_t  ab_s1;

	prod_t   fs_prod;
	frac_t   omf;
	prod_t   nfs_prod;

	// hue * 6 as 4*hue + 2*hue
	assign h6   = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
	assign a255 = {alpha, 8'b0} - {8'b0, alpha};
	assign ab   = a255[FRAC_BITS+8] ? 8'hFF : a255[FRAC_BITS+7:FRAC_BITS];

	always_ff @(posedge clk) begin
		if (en.s1) begin
			sector_s1 <= h6[H6_W-1:FRAC_BITS];
			f_s1      <= h6[FRAC_BITS-1:0];
			s_s1      <= sat_one(saturation);
			v_s1      <= sat_one(brightness);
			ab_s1     <= ab;
		end
	end

	assign fs_prod  = PROD_W'(f_s1) * PROD_W'(s_s1);
	assign omf      = ONE - {1'b0, f_s1};
	assign nfs_prod = PROD_W'(omf) * PROD_W'(s_s1);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			sector_s2 <= sector_s1;
			fs_s2     <= fs_prod[2*FRAC_BITS-1:FRAC_BITS];
			nfs_s2    <= nfs_prod[2*FRAC_BITS:FRAC_BITS];
			oms_s2    <= ONE - s_s1;
			v_s2      <= v_s1;
			ab_s2     <= ab_s1;
		end
	end

endmodule

### hdl/hsva_level.sv
// Stages 3 and 4: v times each complement, then scale by 255 and round to bytes.
// Depends on hsva_pkg.
module hsva_level
	import hsva_pkg::*;
(
	input  logic     clk,
	input  pipe_en_t en,
	input  sector_t  sector_s2,
	input  ffrac_t   fs_s2,
	input  frac_t    nfs_s2,
	input  frac_t    oms_s2,
	input  frac_t    v_s2,
	input  level_t   ab_s2,
	output sector_t  sector_s4,
	output level_t   lp_s4,
	output level_t   lq_s4,
	output level_t   lt_s4,
	output level_t   lv_s4,
	output level_t   ab_s4
);

	frac_t                  m_q;
	frac_t                  m_t;
	logic [FRAC_BITS+8:0]   lv_sum;

	prod_t   pp_s3;
	prod_t   pq_s3;
	prod_t   pt_s3;
	level_t  lv_s3;
	sector_t sector_s3;
	level_t  ab_s3;

	assign m_q    = ONE - {1'b0, fs_s2};
	assign m_t    = ONE - nfs_s2;
	// full level needs no multiplier: (255*v + half) / ONE
	assign lv_sum = {v_s2, 8'b0} - {8'b0, v_s2}
		+ ((FRAC_BITS + 9)'(1) << (FRAC_BITS - 1));

	always_ff @(posedge clk) begin
		if (en.s3) begin
			pp_s3     <= PROD_W'(v_s2) * PROD_W'(oms_s2);
			pq_s3     <= PROD_W'(v_s2) * PROD_W'(m_q);
			pt_s3     <= PROD_W'(v_s2) * PROD_W'(m_t);
			lv_s3     <= lv_sum[FRAC_BITS+7:FRAC_BITS];
			sector_s3 <= sector_s2;
			ab_s3     <= ab_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			lp_s4     <= round_level(pp_s3);
			lq_s4     <= round_level(pq_s3);
			lt_s4     <= round_level(pt_s3);
			lv_s4     <= lv_s3;
			sector_s4 <= sector_s3;
			ab_s4     <= ab_s3;
		end
	end

endmodule

### hdl/hsva_pack.sv
// Stage 5: route the four levels to red, green and blue by sector and pack ARGB.
// Depends on hsva_pkg.
module hsva_pack
	import hsva_pkg::*;
(
	input  logic        clk,
	input  pipe_en_t    en,
	input  sector_t     sector_s4,
	input  level_t      lp_s4,
	input  level_t      lq_s4,
	input  level_t      lt_s4,
	input  level_t      lv_s4,
	input  level_t      ab_s4,
	output logic [31:0] argb_s5
);

	logic [23:0] rgb;

	always_comb begin
		case (sector_s4)
			SEC_RED:     rgb = {lv_s4, lt_s4, lp_s4};
			SEC_YELLOW:  rgb = {lq_s4, lv_s4, lp_s4};
			SEC_GREEN:   rgb = {lp_s4, lv_s4, lt_s4};
			SEC_CYAN:    rgb = {lp_s4, lq_s4, lv_s4};
			SEC_BLUE:    rgb = {lt_s4, lp_s4, lv_s4};
			SEC_MAGENTA: rgb = {lv_s4, lp_s4, lq_s4};
			default:     rgb = 24'h0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			argb_s5 <= {ab_s4, rgb};
		end
	end

endmodule

### hdl/hsv_alpha_to_argb.sv
// HSV plus alpha to packed ARGB converter, top level. Depends on hsva_pkg,
// hsva_prep, hsva_level and hsva_pack.
//
// Takes one pixel request per clock while pix_stall is low (hue, saturation,
// brightness, alpha as unsigned Q1.16 fractions) and returns one 32-bit ARGB
// word per request, in order. The five register stages are: hue split and
// clamping, the f*s products, the v*(1-x) products, scaling by 255 with
// half-up rounding, and sector routing. Throughput is one request per cycle
// unless the output stalls; each stage advances independently, so bubbles close
// up under output stall and pix_stall rises only when all five stages hold data
// and argb_stall is high. A hue of 1.0 or more gives zero
// color bytes; saturation and brightness above 1.0 act as 1.0; the alpha byte
// is floor(255*alpha) clamped to 255.
module hsv_alpha_to_argb
	import hsva_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pix_valid,
	output logic        pix_stall,
	input  frac_t       hue,
	input  frac_t       saturation,
	input  frac_t       brightness,
	input  frac_t       alpha,
	output logic        argb_valid,
	input  logic        argb_stall,
	output logic [31:0] argb
);

	pipe_en_t en;
	logic     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	sector_t sector_s2, sector_s4;
	ffrac_t  fs_s2;
	frac_t   nfs_s2, oms_s2, v_s2;
	level_t  ab_s2, ab_s4;
	level_t  lp_s4, lq_s4, lt_s4, lv_s4;

	// A stage advances when it is empty or the next one advances.
	assign en.s5 = !vld_s5 || !argb_stall;
	assign en.s4 = !vld_s4 || en.s5;
	assign en.s3 = !vld_s3 || en.s4;
	assign en.s2 = !vld_s2 || en.s3;
	assign en.s1 = !vld_s1 || en.s2;

	assign pix_stall  = !en.s1;
	assign argb_valid = vld_s5;

	// Valid bits travel with the data; hold them while the stage is blocked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en.s1) vld_s1 <= pix_valid;
			if (en.s2) vld_s2 <= vld_s1;
			if (en.s3) vld_s3 <= vld_s2;
			if (en.s4) vld_s4 <= vld_s3;
			if (en.s5) vld_s5 <= vld_s4;
		end
	end

	hsva_prep u_prep (
		.clk        (clk),
		.en         (en),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.alpha      (alpha),
		.sector_s2  (sector_s2),
		.fs_s2      (fs_s2),
		.nfs_s2     (nfs_s2),
		.oms_s2     (oms_s2),
		.v_s2       (v_s2),
		.ab_s2      (ab_s2)
	);

	hsva_level u_level (
		.clk       (clk),
		.en        (en),
		.sector_s2 (sector_s2),
		.fs_s2     (fs_s2),
		.nfs_s2    (nfs_s2),
		.oms_s2    (oms_s2),
		.v_s2      (v_s2),
		.ab_s2     (ab_s2),
		.sector_s4 (sector_s4),
		.lp_s4     (lp_s4),
		.lq_s4     (lq_s4),
		.lt_s4     (lt_s4),
		.lv_s4     (lv_s4),
		.ab_s4     (ab_s4)
	);

	hsva_pack u_pack (
		.clk       (clk),
		.en        (en),
		.sector_s4 (sector_s4),
		.lp_s4     (lp_s4),
		.lq_s4     (lq_s4),
		.lt_s4     (lt_s4),
		.lv_s4     (lv_s4),
		.ab_s4     (ab_s4),
		.argb_s5   (argb)
	);

	// Input backpressure only when every stage is full and the output is stalled.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && argb_stall))
		else $error("input stalled while pipeline has room");

	// A request leaving stage 4 into a free output stage must show up at the output.
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(en.s5 && vld_s4) |=> argb_valid)
		else $error("request lost between stage 4 and output");

	// An idle input cycle that is taken leaves a bubble in stage 1.
	a_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(en.s1 && !pix_valid) |=> !vld_s1)
		else $error("stage 1 marked valid without a request");

endmodule

### test/hsv_alpha_to_argb_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for hsv_alpha_to_argb: predicts each ARGB word from the accepted
// pixel request and compares in order. Depends on hsva_pkg and the hsv_alpha_to_argb RTL.
module hsv_alpha_to_argb_tb
	import hsva_pkg::*;
();

	localparam int CLK_HALF      = 6;
	localparam int RANDOM_PIXELS = 400;
	localparam int DRAIN_CYCLES  = 20;      // pipeline is five stages deep
	localparam int CYCLE_LIMIT   = 200000;  // far beyond the slowest legal run

	typedef enum {ARGB_MATCH, ARGB_WRONG, ARGB_UNEXPECTED} argb_verdict_e;
	typedef enum {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_BLOCKS} stall_mode_e;

	// Holds the predicted ARGB words of accepted requests, oldest first.
	class argb_tracker;
		logic [31:0] pending_argb[$];

		function logic [63:0] clamp_unit(logic [63:0] x);
			logic [63:0] unit_v;
			unit_v = 64'd1 << FRAC_BITS;
			return (x > unit_v) ? unit_v : x;
		endfunction

		// 255 * v * m / ONE^2 with half-up rounding
		function logic [7:0] scale_level(logic [63:0] v, logic [63:0] m);
			logic [63:0] prod;
			prod = 64'd255 * v * m + (64'd1 << (2 * FRAC_BITS - 1));
			prod = prod >> (2 * FRAC_BITS);
			return prod[7:0];
		endfunction

		function void note_pixel(frac_t h, frac_t s_in, frac_t b_in, frac_t a);
			logic [63:0] unit_v, s, v, h6, f, fs, nfs, ab;
			sector_t     sec;
			logic [7:0]  lp, lq, lt, lv;
			logic [23:0] rgb;
			unit_v = 64'd1 << FRAC_BITS;
			s   = clamp_unit(64'(s_in));
			v   = clamp_unit(64'(b_in));
			h6  = 64'(h) * 64'd6;
			sec = sector_t'(h6 >> FRAC_BITS);
			f   = h6 & (unit_v - 64'd1);
			fs  = (f * s) >> FRAC_BITS;
			nfs = ((unit_v - f) * s) >> FRAC_BITS;
			lp  = scale_level(v, unit_v - s);
			lq  = scale_level(v, unit_v - fs);
			lt  = scale_level(v, unit_v - nfs);
			lv  = scale_level(v, unit_v);
			case (sec)
				SEC_RED:     rgb = {lv, lt, lp};
				SEC_YELLOW:  rgb = {lq, lv, lp};
				SEC_GREEN:   rgb = {lp, lv, lt};
				SEC_CYAN:    rgb = {lp, lq, lv};
				SEC_BLUE:    rgb = {lt, lp, lv};
				SEC_MAGENTA: rgb = {lv, lp, lq};
				default:     rgb = '0;
			endcase
			ab = (64'd255 * 64'(a)) >> FRAC_BITS;
			if (ab > 64'd255)
				ab = 64'd255;
			pending_argb.push_back({ab[7:0], rgb});
		endfunction

		function argb_verdict_e check_argb(logic [31:0] got, output logic [31:0] want);
			if (pending_argb.size() == 0) begin
				want = '0;
				return ARGB_UNEXPECTED;
			end
			want = pending_argb.pop_front();
			return (got === want) ? ARGB_MATCH : ARGB_WRONG;
		endfunction

		function int pending();
			return pending_argb.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        pix_valid;
	logic        pix_stall;
	frac_t       hue;
	frac_t       saturation;
	frac_t       brightness;
	frac_t       alpha;
	logic        argb_valid;
	logic        argb_stall;
	logic [31:0] argb;

	argb_tracker   tracker;
	int            fail_count = 0;
	int            cycle_count = 0;
	int            burst_left = 0;
	stall_mode_e   stall_mode = FLOW_FREE;
	int            mode_left = 0;
	logic [31:0]   want_argb;
	argb_verdict_e verdict;

	hsv_alpha_to_argb dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.alpha      (alpha),
		.argb_valid (argb_valid),
		.argb_stall (argb_stall),
		.argb       (argb)
	);

	initial clk = 1'b0;

	// 12 ns period: high half, then low half
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Print one line per failure and count it; the run carries on.
	task report_mismatch(input string what);
		$display("[%0t] ERROR: %s", $time, what);
		fail_count++;
	endtask

	// Sender pacing: run a burst of back-to-back requests, then drop valid for a
	// random gap. Every so often a long burst gives a stretch with no idling.
	task pace();
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				@(negedge clk);
				pix_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
		end
		burst_left--;
	endtask

	// Present one pixel request, hold it while stalled, record it once accepted.
	task send_pixel(input frac_t h, input frac_t s, input frac_t b, input frac_t a);
		pace();
		@(negedge clk);
		pix_valid  <= 1'b1;
		hue        <= h;
		saturation <= s;
		brightness <= b;
		alpha      <= a;
		do
			@(posedge clk);
		while (pix_stall);
		tracker.note_pixel(h, s, b, a);
	endtask

	// Mostly in-range fractions, with the edges and the full 17-bit range mixed in
	// so that every input bit toggles and the clamps get exercised.
	function frac_t pick_frac();
		int r;
		r = $urandom_range(0, 19);
		if (r < 3) begin
			case ($urandom_range(0, 3))
				0:       return frac_t'(0);
				1:       return frac_t'(1);
				2:       return frac_t'(65535);
				default: return ONE;
			endcase
		end
		if (r < 5)
			return frac_t'($urandom_range(0, (1 << IN_W) - 1));
		return frac_t'($urandom_range(0, 1 << FRAC_BITS));
	endfunction

	// Receiver: switch to a randomly chosen flow pattern when the current one runs
	// out; the block pattern holds stall long enough to fill every pipeline stage.
	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= stall_mode_e'($urandom_range(0, 3));
			mode_left  <= $urandom_range(16, 80);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			FLOW_FREE:  argb_stall <= 1'b0;
			FLOW_LIGHT: argb_stall <= ($urandom_range(0, 9) < 3);
			FLOW_HEAVY: argb_stall <= ($urandom_range(0, 9) < 7);
			default:    argb_stall <= ((mode_left % 16) < 11);
		endcase
	end

	// Output monitor and watchdog. Sample at the rising edge, before the block's
	// registers update; check each accepted word against the oldest prediction.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else if (arst_n && argb_valid && !argb_stall) begin
			verdict = tracker.check_argb(argb, want_argb);
			if (verdict == ARGB_UNEXPECTED)
				report_mismatch($sformatf("argb %08h with no request outstanding", argb));
			else if (verdict == ARGB_WRONG)
				report_mismatch($sformatf("argb got %08h, want %08h", argb, want_argb));
		end
	end

	initial begin
		tracker    = new;
		arst_n     = 1'b0;
		pix_valid  = 1'b0;
		hue        = '0;
		saturation = '0;
		brightness = '0;
		alpha      = '0;
		argb_stall = 1'b0;

		// hold reset, then release it away from the rising edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: black, full-scale red, and the hue of exactly 1.0 (black color
		// bytes, alpha still placed)
		send_pixel(17'd0,      17'd0,      17'd0,      17'd0);
		send_pixel(17'd0,      17'd65536,  17'd65536,  17'd65536);
		send_pixel(17'd65536,  17'd65536,  17'd65536,  17'd65536);
		// everything above 1.0: hue past the circle, clamped s and v, saturated alpha
		send_pixel(17'd131071, 17'd131071, 17'd131071, 17'd131071);
		send_pixel(17'd65537,  17'd40000,  17'd50000,  17'd1);
		send_pixel(17'd65535,  17'd65536,  17'd65536,  17'd65535);
		// one request in each of the six sectors
		for (int k = 0; k < 6; k++)
			send_pixel(frac_t'(k * 10923 + 3000), 17'd40000, 17'd50000, 17'd32768);
		// sector edges: last hue of red, first of yellow, cyan with f of zero
		send_pixel(17'd10922,  17'd65536,  17'd65536,  17'd65536);
		send_pixel(17'd10923,  17'd65536,  17'd65536,  17'd65536);
		send_pixel(17'd32768,  17'd65536,  17'd65536,  17'd0);
		// gray (no saturation), clamped brightness, clamped saturation
		send_pixel(17'd20000,  17'd0,      17'd65536,  17'd1);
		send_pixel(17'd40000,  17'd30000,  17'd100000, 17'd70000);
		send_pixel(17'd50000,  17'd90000,  17'd30000,  17'd65536);
		send_pixel(17'd60000,  17'd1,      17'd1,      17'd256);

		// Random pixel stream
		for (int n = 0; n < RANDOM_PIXELS; n++)
			send_pixel(pick_frac(), pick_frac(), pick_frac(), pick_frac());

		// drop valid, drain the pipeline, then allow for stray words
		@(negedge clk);
		pix_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
